[sv/cia_pkg.sv]
package cia_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_FACT = 3'd5
    } op_t;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_OVF     = 3'd1;
    localparam logic [2:0] ERR_DIVZ    = 3'd2;
    localparam logic [2:0] ERR_NEGEXP  = 3'd3;
    localparam logic [2:0] ERR_NEGFACT = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         error_code;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_POWMUL,
        ST_DONE
    } state_t;

endpackage

[sv/checked_integer_alu.sv]
// Checked integer ALU.
// Input channel s_valid/s_ready carries one word: operation, operand A and
// operand B. Result channel m_valid/m_ready returns one word per input: a
// signed 64-bit value and an error code (value is zero when error is set).
// Add, subtract and trivial cases go from idle straight to the done state.
// Multiply uses a shift-add unit, one bit of B per cycle. Divide uses a
// restoring divider, one quotient bit per cycle. Power and factorial
// repeat the serial multiply: power takes up to 64 products (bounded by
// overflow) and factorial up to 19.
// The serial 64-bit shift-add multiplier sets the rate of these two.
// One word is worked on at a time; s_ready is high only when idle.
// A finished result is held in the output register while m_ready is low;
// the block takes no new word until it has been accepted.
// Reset (aresetn low, synchronous) returns the block to idle with no
// pending result.
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    state_t state_reg, state_next;

    logic [2:0]  op_reg;
    logic        neg_reg;          // sign of final result
    logic [63:0] mcand_reg;        // shifting multiplicand (mul) / running product (pow, fact)
    logic [63:0] mplier_reg;       // shifting multiplier
    logic [64:0] acc_reg;          // product accumulator with carry bit
    logic [63:0] absb_reg;         // |base| (pow) / current factor k (fact)
    logic [31:0] cnt_reg;          // remaining steps
    logic [6:0]  bit_reg;          // bit counter in serial unit
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        ovf_reg;          // product overflow seen in power/factorial multiply
    logic [63:0] val_reg;
    logic [2:0]  err_reg;

    logic [63:0] limit;
    assign limit = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_DONE);
    assign m_data.value = val_reg;
    assign m_data.error_code = err_reg;

    // operand decode
    logic signed [32:0] sum_w, dif_w;
    logic [31:0] abs_a, abs_b;
    assign sum_w = {s_data.operand_a[31], s_data.operand_a} + {s_data.operand_b[31], s_data.operand_b};
    assign dif_w = {s_data.operand_a[31], s_data.operand_a} - {s_data.operand_b[31], s_data.operand_b};
    assign abs_a = s_data.operand_a[31] ? (~s_data.operand_a + 32'd1) : s_data.operand_a;
    assign abs_b = s_data.operand_b[31] ? (~s_data.operand_b + 32'd1) : s_data.operand_b;

    logic [64:0] acc_add;
    logic [32:0] rem_sh;
    logic [32:0] rem_dif;
    logic [63:0] mag32;
    assign acc_add = acc_reg + (mplier_reg[0] ? {1'b0, mcand_reg} : 65'd0);
    assign rem_sh  = {rem_reg, mplier_reg[31]};
    assign rem_dif = rem_sh - {1'b0, dvs_reg};
    assign mag32   = acc_reg[63:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DONE;
                    if (s_data.req_type == OP_MUL) begin
                        state_next = ST_MUL;
                    end else if (s_data.req_type == OP_DIV && s_data.operand_b != 32'd0) begin
                        state_next = ST_DIV;
                    end else if (s_data.req_type == OP_POW && s_data.operand_a != 32'd0
                                 && !s_data.operand_b[31] && abs_a > 32'd1
                                 && s_data.operand_b != 32'd0) begin
                        state_next = ST_POWMUL;
                    end else if (s_data.req_type == OP_FACT && !s_data.operand_a[31]
                                 && s_data.operand_a > 32'd1 && s_data.operand_a <= 32'd20) begin
                        state_next = ST_POWMUL;
                    end
                end
            end
            ST_MUL:    if (bit_reg == 7'd32) state_next = ST_DONE;
            ST_DIV:    if (bit_reg == 7'd32) state_next = ST_DONE;
            ST_POWMUL: begin
                if (bit_reg == 7'd64 && (ovf_reg || acc_reg[64] || acc_reg[63:0] > limit
                                         || cnt_reg == 32'd1))
                    state_next = ST_DONE;
            end
            ST_DONE:   if (m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                op_reg  <= s_data.req_type;
                bit_reg <= '0;
                acc_reg <= '0;
                ovf_reg <= 1'b0;
                val_reg <= '0;
                err_reg <= ERR_OK;
                neg_reg <= s_data.operand_a[31] ^ s_data.operand_b[31];
                unique case (s_data.req_type)
                    OP_ADD: begin
                        if (sum_w[32] != sum_w[31]) err_reg <= ERR_OVF;
                        else val_reg <= {{32{sum_w[31]}}, sum_w[31:0]};
                    end
                    OP_SUB: begin
                        if (dif_w[32] != dif_w[31]) err_reg <= ERR_OVF;
                        else val_reg <= {{32{dif_w[31]}}, dif_w[31:0]};
                    end
                    OP_MUL: begin
                        mcand_reg  <= {32'd0, abs_a};
                        mplier_reg <= {32'd0, abs_b};
                    end
                    OP_DIV: begin
                        if (s_data.operand_b == 32'd0) err_reg <= ERR_DIVZ;
                        mplier_reg <= {32'd0, abs_a};
                        dvs_reg    <= abs_b;
                        rem_reg    <= '0;
                        quo_reg    <= '0;
                    end
                    OP_POW: begin
                        absb_reg   <= {32'd0, abs_a};
                        neg_reg    <= s_data.operand_a[31] & s_data.operand_b[0];
                        cnt_reg    <= s_data.operand_b;
                        mcand_reg  <= 64'd1;
                        mplier_reg <= {32'd0, abs_a};
                        if (s_data.operand_a == 32'd0)
                            val_reg <= (s_data.operand_b == 32'd0) ? 64'd1 : 64'd0;
                        else if (s_data.operand_b[31])
                            err_reg <= ERR_NEGEXP;
                        else if (s_data.operand_b == 32'd0 || s_data.operand_a == 32'd1)
                            val_reg <= 64'd1;
                        else if (s_data.operand_a == 32'hFFFF_FFFF)
                            val_reg <= s_data.operand_b[0] ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd1;
                    end
                    OP_FACT: begin
                        neg_reg    <= 1'b0;
                        // multiply up from 2: product *= k for k = 2..a
                        cnt_reg    <= s_data.operand_a - 32'd1;
                        absb_reg   <= 64'd2;
                        mcand_reg  <= 64'd1;
                        mplier_reg <= 64'd2;
                        if (s_data.operand_a[31]) err_reg <= ERR_NEGFACT;
                        else if (s_data.operand_a > 32'd20) err_reg <= ERR_OVF;
                        else val_reg <= 64'd1;
                    end
                    default: ;
                endcase
            end
            ST_MUL: begin
                bit_reg <= bit_reg + 7'd1;
                if (bit_reg != 7'd32) begin
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[63:1]};
                end else begin
                    if (neg_reg ? (mag32 > 64'h8000_0000) : (mag32 > 64'h7FFF_FFFF))
                        err_reg <= ERR_OVF;
                    else
                        val_reg <= neg_reg ? (~mag32 + 64'd1) : mag32;
                end
            end
            ST_DIV: begin
                bit_reg <= bit_reg + 7'd1;
                if (bit_reg != 7'd32) begin
                    mplier_reg <= {mplier_reg[62:0], 1'b0};
                    if (rem_sh >= {1'b0, dvs_reg}) begin
                        rem_reg <= rem_dif[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                end else begin
                    if (!neg_reg && quo_reg[31])
                        err_reg <= ERR_OVF;
                    else
                        val_reg <= neg_reg ? (~{32'd0, quo_reg} + 64'd1) : {32'd0, quo_reg};
                end
            end
            ST_POWMUL: begin
                // one bit of the multiplier per cycle; flag a carry out or a lost
                // multiplicand bit that a later multiplier bit would still need
                if (bit_reg != 7'd64) begin
                    bit_reg <= bit_reg + 7'd1;
                    if (acc_add[64] || (mcand_reg[63] && (|mplier_reg[63:1])))
                        ovf_reg <= 1'b1;
                    acc_reg    <= acc_add;
                    mcand_reg  <= {mcand_reg[62:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[63:1]};
                end else begin
                    bit_reg <= '0;
                    ovf_reg <= 1'b0;
                    if (ovf_reg || acc_reg[64] || acc_reg[63:0] > limit) begin
                        err_reg <= ERR_OVF;
                        val_reg <= '0;
                    end else begin
                        if (cnt_reg == 32'd1)
                            val_reg <= neg_reg ? (~acc_reg[63:0] + 64'd1) : acc_reg[63:0];
                        cnt_reg <= cnt_reg - 32'd1;
                        acc_reg <= '0;
                        if (op_reg == OP_FACT) begin
                            absb_reg   <= absb_reg + 64'd1;
                            mcand_reg  <= acc_reg[63:0];
                            mplier_reg <= absb_reg + 64'd1;
                        end else begin
                            mcand_reg  <= acc_reg[63:0];
                            mplier_reg <= absb_reg;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code != ERR_OK |-> m_data.value == 64'd0)
        else $error("nonzero value with error");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("ready while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("held result changed");

endmodule
